@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the estimator rtl
// no dependencies; compiles to nothing when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: property violated");

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication violated");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication violated");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/ske_pkg.sv @@
// shared types and fixed constants for the scalar kalman estimator
// no dependencies
package ske_pkg;

    localparam int MEAS_W      = 16;
    localparam int GAIN_W      = 16;
    localparam int NOISE_W     = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_PROCESS_NOISE     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEASUREMENT_NOISE = 1'b1;

    localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST     = 16'd160;
    localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RST = 16'd640;

    // unity gain in q1.16, one bit wider than the gain
    localparam logic [GAIN_W:0] GAIN_ONE = {1'b1, {GAIN_W{1'b0}}};

    // status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } ske_unit_stat_t;

endpackage

@@ rtl/core/scalar_kalman_estimator.sv @@
// One-dimensional Kalman filter for distance readings. Each accepted measurement
// word yields one result word (filtered estimate in q16.0, gain in q0.16), and
// the next measurement is not accepted until the previous one is through:
// a bit-serial divider forms the gain, then two shift-add multipliers run side
// by side for the estimate step and the variance update.
// A finished result sits in an output register, so a new measurement is taken
// while it waits. Configuration writes are taken at any time but are meant
// for idle periods; the registers are process noise (index 0) and measurement
// noise (index 1). Depends on ske_pkg, ske_div, ske_mul and assert_macros.svh.
`include "assert_macros.svh"

module scalar_kalman_estimator #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ske_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ske_pkg::NOISE_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ske_pkg::MEAS_W-1:0]        measurement,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ske_pkg::MEAS_W-1:0]        filtered_estimate,
    output logic [ske_pkg::GAIN_W-1:0]        gain
);
    import ske_pkg::*;

    localparam int EST_BITS = MEAS_W + FRAC_BITS;
    localparam int VAR_BITS = MEAS_W + 2 + FRAC_BITS;
    localparam int DEN_W    = VAR_BITS + 1;
    localparam int MB_W     = GAIN_W + 1;
    localparam logic [VAR_BITS-1:0] VAR_MAX = {VAR_BITS{1'b1}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [NOISE_W-1:0]  process_noise_reg;
    logic [NOISE_W-1:0]  measurement_noise_reg;
    logic [EST_BITS-1:0] est_reg;
    logic [VAR_BITS-1:0] var_reg;
    logic [MEAS_W-1:0]   meas_reg;
    logic [GAIN_W-1:0]   k_reg;
    logic                up_reg;
    logic                out_valid_reg;
    logic [MEAS_W-1:0]   filtered_estimate_reg;
    logic [GAIN_W-1:0]   gain_reg;

    logic                in_take;
    logic                out_free;
    logic [DEN_W-1:0]    den;
    logic [GAIN_W-1:0]   quotient;
    logic [EST_BITS-1:0] meas_ext;
    logic                innov_up;
    logic [EST_BITS-1:0] innov_mag;
    logic [MB_W-1:0]     one_minus_k;
    logic [EST_BITS+MB_W-1:0] prod_est;
    logic [VAR_BITS+MB_W-1:0] prod_var;
    logic [EST_BITS-1:0] est_step;
    logic [EST_BITS-1:0] est_new;
    logic [VAR_BITS:0]   var_sum;
    logic [VAR_BITS-1:0] var_new;

    ske_unit_stat_t div_stat;
    ske_unit_stat_t mul_est_stat;
    ske_unit_stat_t mul_var_stat;

    assign in_ready  = state_reg == S_IDLE;
    assign in_take   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    // gain denominator p + (r << frac)
    assign den = {1'b0, var_reg} + DEN_W'({measurement_noise_reg, {FRAC_BITS{1'b0}}});

    ske_div #(
        .NUM_W (VAR_BITS),
        .DEN_W (DEN_W),
        .Q_W   (GAIN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_take),
        .numer    (var_reg),
        .denom    (den),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // innovation as sign and magnitude
    assign meas_ext    = {meas_reg, {FRAC_BITS{1'b0}}};
    assign innov_up    = meas_ext >= est_reg;
    assign innov_mag   = innov_up ? (meas_ext - est_reg) : (est_reg - meas_ext);
    assign one_minus_k = GAIN_ONE - {1'b0, k_reg};

    ske_mul #(
        .A_W (EST_BITS),
        .B_W (MB_W)
    ) u_mul_est (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == S_SETUP),
        .a       (innov_mag),
        .b       ({1'b0, k_reg}),
        .product (prod_est),
        .stat    (mul_est_stat)
    );

    ske_mul #(
        .A_W (VAR_BITS),
        .B_W (MB_W)
    ) u_mul_var (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == S_SETUP),
        .a       (var_reg),
        .b       (one_minus_k),
        .product (prod_var),
        .stat    (mul_var_stat)
    );

    // step is truncated toward zero, so the estimate never leaves its range
    assign est_step = prod_est[EST_BITS+GAIN_W-1:GAIN_W];
    assign est_new  = up_reg ? (est_reg + est_step) : (est_reg - est_step);

    assign var_sum = {1'b0, prod_var[VAR_BITS+GAIN_W-1:GAIN_W]}
                   + (VAR_BITS+1)'({process_noise_reg, {FRAC_BITS{1'b0}}});
    assign var_new = var_sum[VAR_BITS] ? VAR_MAX : var_sum[VAR_BITS-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mul_est_stat.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= S_IDLE;
            process_noise_reg     <= PROCESS_NOISE_RST;
            measurement_noise_reg <= MEASUREMENT_NOISE_RST;
            est_reg               <= '0;
            var_reg               <= '0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_PROCESS_NOISE:     process_noise_reg     <= cfg_data;
                    CFG_MEASUREMENT_NOISE: measurement_noise_reg <= cfg_data;
                endcase
            end
            if (state_reg == S_MUL && mul_est_stat.done)
            begin
                est_reg <= est_new;
                var_reg <= var_new;
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            meas_reg <= measurement;
        end
        if (state_reg == S_DIV && div_stat.done)
        begin
            k_reg <= quotient;
        end
        if (state_reg == S_SETUP)
        begin
            up_reg <= innov_up;
        end
        if (state_reg == S_DONE && out_free)
        begin
            filtered_estimate_reg <= est_reg[EST_BITS-1:FRAC_BITS];
            gain_reg              <= k_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign filtered_estimate = filtered_estimate_reg;
    assign gain              = gain_reg;

    `ASSERT_NEXT(a_take_starts_div, clk, rst_n, in_take, div_stat.busy)
    `ASSERT_PROP(a_muls_in_step, clk, rst_n, mul_est_stat.done == mul_var_stat.done)
    `ASSERT_IMPLY(a_mul_state_active, clk, rst_n, state_reg == S_MUL, mul_est_stat.busy || mul_est_stat.done)

endmodule

@@ rtl/core/ske_div.sv @@
// serial restoring divider, one quotient bit per cycle, for numer <= denom
// depends on ske_pkg and assert_macros.svh
`include "assert_macros.svh"

module ske_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 35,
    parameter int Q_W   = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [NUM_W-1:0]         numer,
    input  logic [DEN_W-1:0]         denom,
    output logic [Q_W-1:0]           quotient,
    output ske_pkg::ske_unit_stat_t  stat
);
    import ske_pkg::*;

    localparam int CNT_W = $clog2(Q_W);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [Q_W-1:0]   q_reg;
    logic             zero_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic             last;

    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};
    assign last    = cnt_reg == CNT_W'(Q_W - 1);

    always_comb
    begin
        if (fits)
        begin
            rem_next = diff[DEN_W-1:0];
        end
        else
        begin
            rem_next = shifted[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= DEN_W'(numer);
            den_reg  <= denom;
            zero_reg <= denom == '0;
            q_reg    <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[Q_W-2:0], fits};
        end
    end

    // a zero denominator yields a zero gain
    assign quotient  = zero_reg ? '0 : q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `ASSERT_IMPLY(a_div_no_restart, clk, rst_n, start, !busy_reg)
    `ASSERT_IMPLY(a_div_numer_le_denom, clk, rst_n, start, DEN_W'(numer) <= denom)
    `ASSERT_IMPLY(a_div_rem_bounded, clk, rst_n, busy_reg, rem_reg <= den_reg)
    `ASSERT_IMPLY(a_div_done_after_busy, clk, rst_n, $fell(busy_reg) && !start, done_reg)

endmodule

@@ rtl/core/ske_mul.sv @@
// serial shift-add multiplier, one multiplier bit per cycle, lsb first
// depends on ske_pkg and assert_macros.svh
`include "assert_macros.svh"

module ske_mul #(
    parameter int A_W = 32,
    parameter int B_W = 17
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [A_W-1:0]           a,
    input  logic [B_W-1:0]           b,
    output logic [A_W+B_W-1:0]       product,
    output ske_pkg::ske_unit_stat_t  stat
);
    import ske_pkg::*;

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W);

    logic [A_W-1:0]   a_reg;
    logic [P_W-1:0]   prod_reg;
    logic [A_W:0]     sum;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             last;

    assign last = cnt_reg == CNT_W'(B_W - 1);

    // add the multiplicand into the upper A_W bits when the current bit is set
    always_comb
    begin
        if (prod_reg[0])
        begin
            sum = {1'b0, prod_reg[P_W-1 -: A_W]} + {1'b0, a_reg};
        end
        else
        begin
            sum = {1'b0, prod_reg[P_W-1 -: A_W]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= a;
            prod_reg <= {{A_W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            prod_reg <= {sum, prod_reg[B_W-1:1]};
        end
    end

    assign product   = prod_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `ASSERT_IMPLY(a_mul_no_restart, clk, rst_n, start, !busy_reg)
    `ASSERT_IMPLY(a_mul_done_idle, clk, rst_n, done_reg, !busy_reg)
    `ASSERT_NEXT(a_mul_done_on_last, clk, rst_n, busy_reg && last && !start, done_reg)

endmodule

@@ bench/scalar_kalman_estimator_tb.sv @@
// self-checking bench for scalar_kalman_estimator: a directed table, then random readings
// every result word is checked against an in-bench kalman update at the same widths
// depends on ske_pkg and the estimator rtl
`timescale 1ns / 1ps

module scalar_kalman_estimator_tb;
    import ske_pkg::*;

    localparam int FRAC = 16;
    localparam int EST_W = 16 + FRAC;
    localparam int VAR_W = 18 + FRAC;
    localparam logic [63:0] VAR_CEIL = (64'd1 << VAR_W) - 64'd1;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASES = 10;
    localparam int PHASE_WORDS = 125;
    localparam int REPORT_MAX = 10;

    typedef enum logic {ROW_MEAS, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [CFG_INDEX_W-1:0]   idx;
        logic [15:0]              value;
        logic                     chk_est;
        logic [15:0]              exp_est;
        logic                     chk_gain;
        logic [15:0]              exp_gain;
    } row_t;

    typedef struct packed {
        logic [MEAS_W-1:0] est;
        logic [GAIN_W-1:0] gain;
    } result_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [NOISE_W-1:0]       cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [MEAS_W-1:0]        measurement;
    logic                     out_valid;
    logic                     out_ready;
    logic [MEAS_W-1:0]        filtered_estimate;
    logic [GAIN_W-1:0]        gain;

    // filter state and noise settings as the block should hold them
    logic [EST_W-1:0]         est_q;
    logic [VAR_W-1:0]         var_q;
    logic [NOISE_W-1:0]       q_noise;
    logic [NOISE_W-1:0]       r_noise;

    result_t                  pending_estimates[$];
    row_t                     plan[$];
    int                       fault_count = 0;
    int                       idle_cycles = 0;
    int                       stall_left = 0;
    bit                       quiet = 1'b0;

    scalar_kalman_estimator #(.FRAC_BITS(FRAC)) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .measurement       (measurement),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .filtered_estimate (filtered_estimate),
        .gain              (gain)
    );

    always #5 clk = ~clk;

    // mostly short gaps, now and then a long one; none in quiet phases
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 4);
        if (roll < 98)
            return $urandom_range(5, 40);
        return $urandom_range(100, 300);
    endfunction

    function automatic void kalman_update(input logic [15:0] value, output result_t res);
        logic [63:0] u;
        logic [63:0] p;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] k;
        logic [63:0] pn;
        u = 64'(value) << FRAC;
        p = 64'(var_q);
        e = 64'(est_q);
        den = p + (64'(r_noise) << FRAC);
        k = 64'd0;
        // zero denominator leaves the gain at zero, unity gain clips to all ones
        if (den != 64'd0)
        begin
            k = (p << 16) / den;
            if (k > 64'd65535)
                k = 64'd65535;
        end
        // step truncates toward zero on either side of the reading
        if (u >= e)
            e = e + ((k * (u - e)) >> 16);
        else
            e = e - ((k * (e - u)) >> 16);
        pn = ((p * (64'(GAIN_ONE) - k)) >> 16) + (64'(q_noise) << FRAC);
        if (pn > VAR_CEIL)
            pn = VAR_CEIL;
        est_q = e[EST_W-1:0];
        var_q = pn[VAR_W-1:0];
        res.est = e[FRAC +: MEAS_W];
        res.gain = k[GAIN_W-1:0];
    endfunction

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_noise(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_PROCESS_NOISE)
            q_noise = value;
        else
            r_noise = value;
    endtask

    // valid stays up across back-to-back words, so it is only lowered ahead of a gap
    task automatic send_measurement(input logic [15:0] value, output result_t pred);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        measurement <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        kalman_update(value, pred);
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_estimates.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("unexpected result word: filtered_estimate %0d gain %0d",
                                 filtered_estimate, gain);
                end
                else
                begin
                    want = pending_estimates.pop_front();
                    if (filtered_estimate !== want.est)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_MAX)
                            $display("filtered_estimate: expected %0d, got %0d",
                                     want.est, filtered_estimate);
                    end
                    if (gain !== want.gain)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_MAX)
                            $display("gain: expected %0d, got %0d", want.gain, gain);
                    end
                end
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left = idle_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        row_t             row;
        result_t          want;
        int               target;
        int               reading;
        int               roll;
        logic [15:0]      q_pick;
        logic [15:0]      r_pick;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PROCESS_NOISE;
        cfg_data = '0;
        in_valid = 1'b0;
        measurement = '0;
        out_ready = 1'b0;
        est_q = '0;
        var_q = '0;
        q_noise = PROCESS_NOISE_RST;
        r_noise = MEASUREMENT_NOISE_RST;

        // first word after reset: zero variance gives zero gain, estimate stays at zero
        plan.push_back(row_t'{ROW_MEAS, CFG_PROCESS_NOISE, 16'd65535, 1'b1, 16'd0, 1'b1, 16'd0});
        plan.push_back(row_t'{ROW_MEAS, CFG_PROCESS_NOISE, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0});
        plan.push_back(row_t'{ROW_MEAS, CFG_PROCESS_NOISE, 16'd65535, 1'b0, 16'd0, 1'b0, 16'd0});
        plan.push_back(row_t'{ROW_MEAS, CFG_PROCESS_NOISE, 16'd1600, 1'b0, 16'd0, 1'b0, 16'd0});
        // no measurement noise with variance left over: unity gain clips
        plan.push_back(row_t'{ROW_CFG, CFG_MEASUREMENT_NOISE, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0});
        plan.push_back(row_t'{ROW_MEAS, CFG_PROCESS_NOISE, 16'd1600, 1'b0, 16'd0, 1'b1, 16'd65535});
        plan.push_back(row_t'{ROW_MEAS, CFG_PROCESS_NOISE, 16'd0, 1'b0, 16'd0, 1'b1, 16'd65535});
        // without process noise the variance runs down to zero
        plan.push_back(row_t'{ROW_CFG, CFG_PROCESS_NOISE, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0});
        plan.push_back(row_t'{ROW_MEAS, CFG_PROCESS_NOISE, 16'd65535, 1'b0, 16'd0, 1'b1, 16'd65535});
        plan.push_back(row_t'{ROW_MEAS, CFG_PROCESS_NOISE, 16'd0, 1'b0, 16'd0, 1'b1, 16'd65535});
        // zero variance and zero measurement noise: empty denominator, gain zero
        plan.push_back(row_t'{ROW_MEAS, CFG_PROCESS_NOISE, 16'd30000, 1'b0, 16'd0, 1'b1, 16'd0});
        plan.push_back(row_t'{ROW_CFG, CFG_PROCESS_NOISE, 16'd65535, 1'b0, 16'd0, 1'b0, 16'd0});
        plan.push_back(row_t'{ROW_CFG, CFG_MEASUREMENT_NOISE, 16'd65535, 1'b0, 16'd0, 1'b0, 16'd0});
        plan.push_back(row_t'{ROW_MEAS, CFG_PROCESS_NOISE, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0});
        plan.push_back(row_t'{ROW_MEAS, CFG_PROCESS_NOISE, 16'd65535, 1'b0, 16'd0, 1'b0, 16'd0});
        plan.push_back(row_t'{ROW_MEAS, CFG_PROCESS_NOISE, 16'd65535, 1'b0, 16'd0, 1'b0, 16'd0});
        plan.push_back(row_t'{ROW_MEAS, CFG_PROCESS_NOISE, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0});
        plan.push_back(row_t'{ROW_CFG, CFG_PROCESS_NOISE, 16'd0, 1'b0, 16'd0, 1'b0, 16'd0});
        plan.push_back(row_t'{ROW_CFG, CFG_MEASUREMENT_NOISE, 16'd1, 1'b0, 16'd0, 1'b0, 16'd0});
        plan.push_back(row_t'{ROW_MEAS, CFG_PROCESS_NOISE, 16'h5555, 1'b0, 16'd0, 1'b0, 16'd0});
        plan.push_back(row_t'{ROW_MEAS, CFG_PROCESS_NOISE, 16'hAAAA, 1'b0, 16'd0, 1'b0, 16'd0});
        plan.push_back(row_t'{ROW_CFG, CFG_PROCESS_NOISE, 16'd160, 1'b0, 16'd0, 1'b0, 16'd0});
        plan.push_back(row_t'{ROW_CFG, CFG_MEASUREMENT_NOISE, 16'd640, 1'b0, 16'd0, 1'b0, 16'd0});
        plan.push_back(row_t'{ROW_MEAS, CFG_PROCESS_NOISE, 16'h8000, 1'b0, 16'd0, 1'b0, 16'd0});
        plan.push_back(row_t'{ROW_MEAS, CFG_PROCESS_NOISE, 16'h7FFF, 1'b0, 16'd0, 1'b0, 16'd0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == ROW_CFG)
                write_noise(row.idx, row.value);
            else
            begin
                send_measurement(row.value, want);
                if (row.chk_est)
                    want.est = row.exp_est;
                if (row.chk_gain)
                    want.gain = row.exp_gain;
                pending_estimates.push_back(want);
            end
        end

        target = $urandom_range(0, 65535);
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    q_pick = 16'd0;
                    r_pick = 16'd1;
                end
                1:
                begin
                    q_pick = 16'd65535;
                    r_pick = 16'd65535;
                end
                2:
                begin
                    q_pick = 16'd0;
                    r_pick = 16'd0;
                end
                3:
                begin
                    q_pick = 16'd65535;
                    r_pick = 16'd0;
                end
                4:
                begin
                    q_pick = 16'd1;
                    r_pick = 16'd65535;
                end
                default:
                begin
                    q_pick = 16'($urandom);
                    r_pick = 16'($urandom);
                    if ($urandom_range(0, 2) == 0)
                        q_pick = 16'($urandom_range(0, 200));
                    if ($urandom_range(0, 2) == 0)
                        r_pick = 16'($urandom_range(0, 1000));
                end
            endcase
            write_noise(CFG_PROCESS_NOISE, q_pick);
            write_noise(CFG_MEASUREMENT_NOISE, r_pick);
            quiet = (ph % 3 == 2);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // hold the sender back until the pipeline has emptied
                if ((ph == 0 && n == PHASE_WORDS / 2) || $urandom_range(0, 99) == 0)
                    drain_results();
                roll = $urandom_range(0, 99);
                if (roll < 75)
                begin
                    // a slowly moving distance with sensor noise on top
                    if ($urandom_range(0, 49) == 0)
                        target = $urandom_range(0, 65535);
                    else
                        target = target + $urandom_range(0, 40) - 20;
                    if (target < 0)
                        target = 0;
                    if (target > 65535)
                        target = 65535;
                    reading = target + $urandom_range(0, 256) - 128;
                    if (reading < 0)
                        reading = 0;
                    if (reading > 65535)
                        reading = 65535;
                end
                else if (roll < 95)
                    reading = $urandom_range(0, 65535);
                else
                    reading = ($urandom_range(0, 1) == 0) ? 0 : 65535;
                send_measurement(16'(reading), want);
                pending_estimates.push_back(want);
            end
        end

        in_valid <= 1'b0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        fault_count += pending_estimates.size();
        if (fault_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
